// ===== sv/simon_pkg.sv =====
package simon_pkg;

  localparam int unsigned WordW    = 16;
  localparam int unsigned BlockW   = 2 * WordW;
  localparam int unsigned KeyW     = 64;
  localparam int unsigned KeyWords = 4;
  localparam int unsigned RoundsDefault = 32;

  localparam logic [WordW-1:0] KeyConst = 16'hfffc;

  // z0 sequence, element 0 first
  localparam int unsigned ZLen = 62;
  localparam logic [0:ZLen-1] ZSeq =
    62'b11111010001001010110000111001101111101000100101011000011100110;

  typedef enum logic [3:0] {
    ST_EXPAND = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_RUN    = 4'b0100,
    ST_HOLD   = 4'b1000
  } ctrl_state_e;

  // shift control for the round key ring
  typedef struct packed {
    logic shl;  // take value from the upper neighbor
    logic shr;  // take value from the lower neighbor
  } key_ctrl_t;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v, input int unsigned s);
    rotl = (v << s) | (v >> (WordW - s));
  endfunction

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] v, input int unsigned s);
    rotr = (v >> s) | (v << (WordW - s));
  endfunction

endpackage

// ===== sv/simon_key_cell.sv =====
module simon_key_cell import simon_pkg::*; (
  input  logic             clk_i,
  input  key_ctrl_t        ctrl_i,
  input  logic [WordW-1:0] from_hi_i,
  input  logic [WordW-1:0] from_lo_i,
  output logic [WordW-1:0] key_o
);

  logic [WordW-1:0] key_q, key_d;

  always_comb begin
    key_d = key_q;
    if (ctrl_i.shl) begin
      key_d = from_hi_i;
    end else if (ctrl_i.shr) begin
      key_d = from_lo_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

// ===== sv/simon_round.sv =====
module simon_round import simon_pkg::*; (
  input  logic              clk_i,
  input  logic              load_i,
  input  logic [BlockW-1:0] block_i,
  input  logic              step_i,
  input  logic              dec_i,
  input  logic [WordW-1:0]  key_i,
  output logic [BlockW-1:0] state_o,
  output logic [BlockW-1:0] next_o
);

  logic [WordW-1:0] x_q, x_d, y_q, y_d;
  logic [WordW-1:0] nx, ny;

  function automatic logic [WordW-1:0] f(input logic [WordW-1:0] v);
    f = (rotl(v, 1) & rotl(v, 8)) ^ rotl(v, 2);
  endfunction

  // one Feistel round, forward or inverse
  always_comb begin
    if (dec_i) begin
      nx = y_q;
      ny = x_q ^ f(y_q) ^ key_i;
    end else begin
      nx = y_q ^ f(x_q) ^ key_i;
      ny = x_q;
    end
  end

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (load_i) begin
      x_d = block_i[BlockW-1:WordW];
      y_d = block_i[WordW-1:0];
    end else if (step_i) begin
      x_d = nx;
      y_d = ny;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
  end

  assign state_o = {x_q, y_q};
  assign next_o  = {nx, ny};

endmodule

// ===== sv/simon32_64_block_cipher_top.sv =====
// Channel   | Direction | Handshake               | Payload
// input     | in        | in_valid_i / in_stall_o | command_i, block_in_i
// output    | out       | out_valid_o/ out_stall_i| block_out_o
// config    | in        | cfg_we_i (no wait)      | cfg_wdata_i (key)
//
// A block is taken from the input while idle, then runs one round per cycle
// through the single round unit, fed by the key ring head.
// After reset and after every key write the ring is refilled, one round key
// per cycle; input is stalled during that sweep.
// A finished result sits in the output register; a stalled output holds the
// round unit until the register frees, then the next block is taken.
module simon32_64_block_cipher_top import simon_pkg::*; #(
  parameter int unsigned ROUNDS = RoundsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [KeyW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              command_i,
  input  logic [BlockW-1:0] block_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BlockW-1:0] block_out_o
);

  localparam int unsigned CntW = $clog2(ROUNDS);

  ctrl_state_e       state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [KeyW-1:0]   key_q;
  logic              dec_q, dec_d;
  logic              out_valid_q, out_valid_d;
  logic [BlockW-1:0] out_q, out_d;

  key_ctrl_t         kctrl;
  logic [WordW-1:0]  cell_key [ROUNDS];
  logic [WordW-1:0]  gen_key, ring_in, head_key;
  logic              round_load, round_step, last, out_free;
  logic [BlockW-1:0] round_state, round_next;
  logic [5:0]        zidx;

  // Key ring: cell i ends up holding round key i. Encrypt rotates down so
  // cell 0 is the head; decrypt rotates up so the top cell is the head.
  // ROUNDS rotations bring the ring back to its rest position.
  for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
    logic [WordW-1:0] hi, lo;
    if (i == ROUNDS - 1) begin : g_top
      assign hi = ring_in;
    end else begin : g_mid
      assign hi = cell_key[i+1];
    end
    if (i == 0) begin : g_bot
      assign lo = cell_key[ROUNDS-1];
    end else begin : g_up
      assign lo = cell_key[i-1];
    end
    simon_key_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (kctrl),
      .from_hi_i (hi),
      .from_lo_i (lo),
      .key_o     (cell_key[i])
    );
  end

  // Expansion: new words enter at the top, so the entries k[i-1], k[i-3] and
  // k[i-4] sit at cells ROUNDS-1, ROUNDS-3, ROUNDS-4.
  always_comb begin
    logic [WordW-1:0] t;
    zidx = 6'(cnt_q) - 6'(KeyWords);
    t = rotr(cell_key[ROUNDS-1], 3) ^ cell_key[ROUNDS-3];
    t = t ^ rotr(t, 1);
    t = t ^ cell_key[ROUNDS-4];
    t = t ^ {{(WordW-1){1'b0}}, ZSeq[zidx]};
    if (6'(cnt_q) < 6'(KeyWords)) begin
      gen_key = key_q[{cnt_q[1:0], 4'b0000} +: WordW];
    end else begin
      gen_key = t ^ KeyConst;
    end
  end

  assign ring_in  = (state_q == ST_EXPAND) ? gen_key : cell_key[0];
  assign head_key = dec_q ? cell_key[ROUNDS-1] : cell_key[0];

  simon_round u_round (
    .clk_i   (clk_i),
    .load_i  (round_load),
    .block_i (block_in_i),
    .step_i  (round_step),
    .dec_i   (dec_q),
    .key_i   (head_key),
    .state_o (round_state),
    .next_o  (round_next)
  );

  assign last     = (cnt_q == CntW'(ROUNDS - 1));
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    dec_d       = dec_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    kctrl       = '0;
    round_load  = 1'b0;
    round_step  = 1'b0;
    unique case (state_q)
      ST_EXPAND: begin
        kctrl.shl = 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (last) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          round_load = 1'b1;
          dec_d      = command_i;
          cnt_d      = '0;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        kctrl.shl  = !dec_q;
        kctrl.shr  = dec_q;
        round_step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (last) begin
          cnt_d = '0;
          if (out_free) begin
            out_d       = round_next;
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_d       = round_state;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_EXPAND;
        cnt_d   = '0;
      end
    endcase
    // key writes are to arrive only while idle, which the block does not enforce; restart the expansion sweep
    if (cfg_we_i) begin
      state_d = ST_EXPAND;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_EXPAND;
      cnt_q       <= '0;
      key_q       <= '0;
      dec_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dec_q       <= dec_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        key_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign block_out_o = out_q;

endmodule

// ===== sim/simon32_64_block_cipher_top_tb.sv =====
`timescale 1ns / 100ps

module simon32_64_block_cipher_top_tb;

  import simon_pkg::BlockW;
  import simon_pkg::KeyW;

  localparam int unsigned CIPHER_ROUNDS = 32;
  localparam int unsigned CLK_HALF = 2;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 230;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  // tail after the last result
  localparam int unsigned DRAIN_CYCLES = 2 * CIPHER_ROUNDS + 8;
  // overall timeout, several times the slowest legal run
  localparam int unsigned TIMEOUT_NS = 2_000_000;

  // Independent key schedule constants: z0 sequence (element 0 first) and c
  localparam logic [0:61] Z0_SEQ =
    62'b11111010001001010110000111001101111101000100101011000011100110;
  localparam logic [15:0] SCHED_CONST = 16'hfffc;

  // Idle profiles: percent of cycles the sender idles / the receiver stalls
  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_profile_e;

  typedef struct packed {
    logic              decrypt;
    logic [BlockW-1:0] block;
  } block_req_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [KeyW-1:0]   cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              command_i = 1'b0;
  logic [BlockW-1:0] block_in_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [BlockW-1:0] block_out_o;

  // Predictor state: the expanded round keys for the key last written
  logic [15:0] round_keys [CIPHER_ROUNDS];

  block_req_t        pending_blocks[$];
  logic [BlockW-1:0] expected_block_out[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  logic        holding_output = 1'b0;
  event        holdoff_go;

  simon32_64_block_cipher_top #(
    .ROUNDS(CIPHER_ROUNDS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .block_in_i (block_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .block_out_o(block_out_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] rol16(input logic [15:0] v, input int unsigned s);
    return (v << s) | (v >> (16 - s));
  endfunction

  function automatic logic [15:0] ror16(input logic [15:0] v, input int unsigned s);
    return (v >> s) | (v << (16 - s));
  endfunction

  function automatic logic [15:0] feistel_mix(input logic [15:0] v);
    return (rol16(v, 1) & rol16(v, 8)) ^ rol16(v, 2);
  endfunction

  // Expand a 64-bit key; k0 (bits 15..0) is the first round key.
  task automatic load_schedule(input logic [KeyW-1:0] key);
    logic [15:0] t;
    for (int i = 0; i < 4; i++) round_keys[i] = key[16*i +: 16];
    for (int i = 4; i < CIPHER_ROUNDS; i++) begin
      t = ror16(round_keys[i-1], 3) ^ round_keys[i-3];
      t = t ^ ror16(t, 1);
      t = t ^ round_keys[i-4] ^ {15'b0, Z0_SEQ[(i-4) % 62]};
      round_keys[i] = t ^ SCHED_CONST;
    end
  endtask

  // Full block transform; x is the high word. Decrypt walks keys backward.
  function automatic logic [BlockW-1:0] simon_crypt(input logic decrypt,
                                                     input logic [BlockW-1:0] blk);
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] t;
    x = blk[31:16];
    y = blk[15:0];
    for (int r = 0; r < CIPHER_ROUNDS; r++) begin
      if (!decrypt) begin
        t = y ^ feistel_mix(x) ^ round_keys[r];
        y = x;
        x = t;
      end else begin
        t = x ^ feistel_mix(y) ^ round_keys[CIPHER_ROUNDS-1-r];
        x = y;
        y = t;
      end
    end
    return {x, y};
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: offers queued blocks, predicts the result on each transfer.
  // A new item is only loaded once the current one has transferred, so the
  // payload never moves while stalled.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_input
    block_req_t req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_block_out.push_back(simon_crypt(command_i, block_in_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = pending_blocks.pop_front();
          in_valid_i <= 1'b1;
          command_i  <= req.decrypt;
          block_in_i <= req.block;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: checks each transfer against the oldest prediction and
  // drives the receiver stall (random, or forced during a hold-off).
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_output
    logic [BlockW-1:0] want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_block_out.size() == 0) begin
          $error("block_out: no result expected, actual %h", block_out_o);
          mismatch_count++;
        end else begin
          want = expected_block_out.pop_front();
          if (block_out_o !== want) begin
            $error("block_out: expected %h actual %h", want, block_out_o);
            mismatch_count++;
          end
        end
      end
      out_stall_i <= holding_output || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing and the
  // block backs up into its input.
  always begin : output_holdoff
    @(holdoff_go);
    holding_output <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk_i);
    holding_output <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_block(input logic decrypt, input logic [BlockW-1:0] blk);
    block_req_t req;
    req.decrypt = decrypt;
    req.block   = blk;
    pending_blocks.push_back(req);
  endtask

  // Idle: nothing queued, nothing offered, nothing outstanding.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_blocks.size() != 0 || in_valid_i || expected_block_out.size() != 0);
  endtask

  // Key write is a single-cycle strobe; the block re-expands and stalls input
  // on its own, so the predictor simply switches schedules here.
  task automatic write_key(input logic [KeyW-1:0] key);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= key;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    load_schedule(key);
  endtask

  task automatic set_idle(input idle_profile_e profile);
    case (profile)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 50;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 50;
      end
      default: begin
        send_idle_pct  = 14;
        recv_stall_pct = 14;
      end
    endcase
  endtask

  initial begin : stimulus
    logic [KeyW-1:0]   phase_key;
    logic [BlockW-1:0] blk;
    idle_profile_e     profile;

    load_schedule('0);
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset key (all zero), field extremes, both directions
    set_idle(IDLE_NONE);
    queue_block(1'b0, 32'h0000_0000);
    queue_block(1'b1, 32'h0000_0000);
    queue_block(1'b0, 32'hffff_ffff);
    queue_block(1'b1, 32'hffff_ffff);
    queue_block(1'b0, 32'h8000_0000);
    queue_block(1'b1, 32'h0000_0001);
    queue_block(1'b0, 32'hffff_0000);
    queue_block(1'b1, 32'h0000_ffff);
    queue_block(1'b0, 32'haaaa_aaaa);
    queue_block(1'b1, 32'h5555_5555);
    wait_idle();

    // All-ones key
    write_key('1);
    queue_block(1'b0, 32'h0000_0000);
    queue_block(1'b1, 32'hffff_ffff);
    wait_idle();

    // Published test vector, forward and back
    write_key(64'h1918_1110_0908_0100);
    queue_block(1'b0, 32'h6565_6877);
    queue_block(1'b1, 32'hc69b_e9bb);
    queue_block(1'b0, 32'h0000_0001);
    queue_block(1'b1, 32'h8000_0000);
    wait_idle();

    // Random phases: cycle through idle profiles, fresh key each phase
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        1:       phase_key = '1;
        4:       phase_key = '0;
        7:       phase_key = 64'h1918_1110_0908_0100;
        default: phase_key = {$urandom(), $urandom()};
      endcase
      write_key(phase_key);
      @(negedge clk_i);
      profile = idle_profile_e'(phase % 4);
      set_idle(profile);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // mostly uniform blocks, some with saturated halves or lone bits
        case ($urandom_range(7))
          0:       blk = {16'h0000, 16'($urandom())};
          1:       blk = {16'($urandom()), 16'hffff};
          2:       blk = 32'h1 << $urandom_range(31);
          3:       blk = ~(32'h1 << $urandom_range(31));
          default: blk = $urandom();
        endcase
        queue_block(1'($urandom_range(1)), blk);
      end
      // no-idle phases also get a long receiver hold-off to back up the pipe
      if (profile == IDLE_NONE) -> holdoff_go;
      wait_idle();
    end

    set_idle(IDLE_NONE);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_block_out.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
